// File: src/cchb_pkg.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: shared definitions
// Types, codes, register map and the CRC-8 function used by the block.
// ----------------------------------------------------------------------------
package cchb_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_NODE_ID      = 3'd0;
	localparam logic [2:0] REG_NODE_STATUS  = 3'd1;
	localparam logic [2:0] REG_COMMAND_ID   = 3'd2;
	localparam logic [2:0] REG_TELEMETRY_ID = 3'd3;
	localparam logic [2:0] REG_HB_BASE_ID   = 3'd4;
	localparam logic [2:0] REG_HB_PERIOD    = 3'd5;

	// Register reset values.
	localparam logic [7:0]  RST_NODE_ID      = 8'd1;
	localparam logic [1:0]  RST_NODE_STATUS  = 2'd0;
	localparam logic [10:0] RST_COMMAND_ID   = 11'h040;
	localparam logic [10:0] RST_TELEMETRY_ID = 11'h120;
	localparam logic [10:0] RST_HB_BASE_ID   = 11'h080;
	localparam logic [7:0]  RST_HB_PERIOD    = 8'd10;

	// Request kinds.
	localparam logic REQ_RX_FRAME = 1'b0;
	localparam logic REQ_TICK     = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS    = 2'd0;
	localparam logic [1:0] KIND_TELEMETRY = 2'd1;
	localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

	// Receive status codes.
	localparam logic [1:0] RXST_NOT_CMD  = 2'd0;
	localparam logic [1:0] RXST_CMD_OK   = 2'd1;
	localparam logic [1:0] RXST_CRC_ERR  = 2'd2;
	localparam logic [1:0] RXST_NONE     = 2'd3;

	// Command byte that clears the counters.
	localparam logic [7:0] CMD_RESET_COUNTS = 8'h01;

	// CRC-8 polynomial and the number of bytes it covers.
	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam int         CRC_BYTES = 6;

	// Configuration register set.
	typedef struct packed {
		logic [7:0]  node_id;
		logic [1:0]  node_status;
		logic [10:0] command_id;
		logic [10:0] telemetry_id;
		logic [10:0] hb_base_id;
		logic [7:0]  hb_period;
	} cfg_t;

	// Input item after the first stage: CRC checks already reduced to flags.
	typedef struct packed {
		logic        req_type;
		logic        is_cmd;
		logic        crc_ok;
		logic        clear_cmd;
		logic        tlm_accepted;
		logic        hb_accepted;
		logic [63:0] tlm_payload;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] frame_id;
		logic [63:0] payload;
		logic [1:0]  rx_status;
		logic [31:0] error_total;
		logic        last;
	} result_t;

	// CRC-8, MSB first, initial value zero, over bytes 0 to 5 of the payload
	// (byte 0 in bits 63 to 56).
	function automatic logic [7:0] crc8_six(input logic [63:0] pl);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 0; i < CRC_BYTES; i++) begin
			crc = crc ^ pl[63 - 8 * i -: 8];
			for (int b = 0; b < 8; b++) begin
				if (crc[7]) begin
					crc = {crc[6:0], 1'b0} ^ CRC_POLY;
				end else begin
					crc = {crc[6:0], 1'b0};
				end
			end
		end
		return crc;
	endfunction

endpackage

// File: src/cchb_in_stage.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: input stage
// Registers each accepted item and reduces the command check to flags.
// ----------------------------------------------------------------------------
module cchb_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [10:0]          frame_id,
	input  logic [63:0]          rx_payload,
	input  logic                 tlm_accepted,
	input  logic                 hb_accepted,
	input  logic [23:0]          latitude,
	input  logic [23:0]          longitude,
	input  logic [7:0]           satellites,
	input  logic [7:0]           fix_kind,
	input  logic [10:0]          command_id,
	input  logic                 take,
	output logic                 valid_s1,
	output cchb_pkg::item_t      item_s1
);

	cchb_pkg::item_t item_d;
	logic            adv;

	// The stage frees when its item moves on in the same cycle.
	assign adv      = valid_s1 && take;
	assign in_ready = !valid_s1 || adv;

	// Command recognition and CRC check of the incoming frame.
	always_comb begin
		item_d.req_type     = req_type;
		item_d.is_cmd       = (frame_id == command_id);
		item_d.crc_ok       = (cchb_pkg::crc8_six(rx_payload) == rx_payload[15:8]);
		item_d.clear_cmd    = (rx_payload[63:56] == cchb_pkg::CMD_RESET_COUNTS);
		item_d.tlm_accepted = tlm_accepted;
		item_d.hb_accepted  = hb_accepted;
		item_d.tlm_payload  = {latitude, longitude, satellites, fix_kind};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: src/cchb_core.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: counter core
// Holds the counters and forms the one or two results of each item.
// ----------------------------------------------------------------------------
module cchb_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cchb_pkg::cfg_t       cfg,
	input  logic                 adv,
	input  cchb_pkg::item_t      item_s1,
	output cchb_pkg::result_t    res0,
	output cchb_pkg::result_t    res1,
	output logic                 two
);

	logic [7:0]  phase_q;
	logic [15:0] uptime_q;
	logic [31:0] sent_q;
	logic [31:0] recv_q;
	logic [31:0] err_q;

	logic [7:0]  phase_inc;
	logic        hb;
	logic [7:0]  phase_d;
	logic [15:0] uptime_d;
	logic [31:0] sent_tlm;
	logic [31:0] sent_d;
	logic [31:0] recv_inc;
	logic [31:0] recv_d;
	logic [31:0] err_inc;
	logic [31:0] err_d;
	logic [1:0]  sent_step;
	logic [1:0]  rx_st;
	logic [10:0] hb_id;

	assign phase_inc = phase_q + 8'd1;
	assign hb        = (item_s1.req_type == cchb_pkg::REQ_TICK) && (phase_inc >= cfg.hb_period);
	assign recv_inc  = recv_q + 32'd1;
	assign err_inc   = err_q + 32'd1;
	assign sent_tlm  = sent_q + {31'd0, item_s1.tlm_accepted};
	assign sent_step = {1'b0, item_s1.tlm_accepted} + {1'b0, hb && item_s1.hb_accepted};
	assign hb_id     = cfg.hb_base_id + {3'd0, cfg.node_id};

	// Next counter values for either kind of item.
	always_comb begin
		phase_d  = phase_q;
		uptime_d = uptime_q;
		sent_d   = sent_q;
		recv_d   = recv_q;
		err_d    = err_q;
		rx_st    = cchb_pkg::RXST_NOT_CMD;
		if (item_s1.req_type == cchb_pkg::REQ_RX_FRAME) begin
			recv_d = recv_inc;
			if (item_s1.is_cmd) begin
				if (item_s1.crc_ok) begin
					rx_st = cchb_pkg::RXST_CMD_OK;
					if (item_s1.clear_cmd) begin
						sent_d = 32'd0;
						recv_d = 32'd0;
						err_d  = 32'd0;
					end
				end else begin
					rx_st = cchb_pkg::RXST_CRC_ERR;
					err_d = err_inc;
				end
			end
		end else begin
			sent_d = sent_q + {30'd0, sent_step};
			if (!item_s1.tlm_accepted) begin
				err_d = err_inc;
			end
			if (hb) begin
				phase_d  = 8'd0;
				uptime_d = uptime_q + 16'd1;
			end else begin
				phase_d = phase_inc;
			end
		end
	end

	// Result items.
	always_comb begin
		res0.error_total = err_d;
		res1.error_total = err_d;
		if (item_s1.req_type == cchb_pkg::REQ_RX_FRAME) begin
			res0.kind      = cchb_pkg::KIND_STATUS;
			res0.frame_id  = 11'd0;
			res0.payload   = 64'd0;
			res0.rx_status = rx_st;
			res0.last      = 1'b1;
		end else begin
			res0.kind      = cchb_pkg::KIND_TELEMETRY;
			res0.frame_id  = cfg.telemetry_id;
			res0.payload   = item_s1.tlm_payload;
			res0.rx_status = cchb_pkg::RXST_NONE;
			res0.last      = !hb;
		end
		res1.kind      = cchb_pkg::KIND_HEARTBEAT;
		res1.frame_id  = hb_id;
		res1.payload   = {cfg.node_id, 6'd0, cfg.node_status, uptime_q,
			sent_tlm[15:0], recv_q[15:0]};
		res1.rx_status = cchb_pkg::RXST_NONE;
		res1.last      = 1'b1;
		two            = hb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 8'd0;
			uptime_q <= 16'd0;
			sent_q   <= 32'd0;
			recv_q   <= 32'd0;
			err_q    <= 32'd0;
		end else if (adv) begin
			phase_q  <= phase_d;
			uptime_q <= uptime_d;
			sent_q   <= sent_d;
			recv_q   <= recv_d;
			err_q    <= err_d;
		end
	end

endmodule

// File: src/cchb_out_stage.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: output stage
// Two result slots; the head slot drives the output, the second follows it.
// ----------------------------------------------------------------------------
module cchb_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  cchb_pkg::result_t    res0,
	input  cchb_pkg::result_t    res1,
	input  logic                 two,
	output logic                 free,
	input  logic                 out_ready,
	output logic                 out_valid,
	output cchb_pkg::result_t    out_res
);

	logic              head_valid_q;
	logic              tail_valid_q;
	cchb_pkg::result_t head_q;
	cchb_pkg::result_t tail_q;
	logic              pop;

	assign pop       = head_valid_q && out_ready;
	assign free      = !head_valid_q || (out_ready && !tail_valid_q);
	assign out_valid = head_valid_q;
	assign out_res   = head_q;

	// Slot control: load a new pair, or move the second result to the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else if (load) begin
			head_valid_q <= 1'b1;
			tail_valid_q <= two;
		end else if (pop) begin
			head_valid_q <= tail_valid_q;
			tail_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res0;
			tail_q <= res1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

// File: src/can_command_check_and_heartbeat.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat node
// Checks received command frames by CRC-8, keeps frame counters, and emits
// telemetry on every tick and a heartbeat every heartbeat_period ticks.
//
// Channel   Role     Content
// s_*       input    received frame or tick; s_tuser = request kind
// m_*       output   status, telemetry or heartbeat result; m_tlast = last
// p*        config   APB register port, six registers at 4*i
//
// An item passes an input register and is turned into its results
// combinationally, so one item per cycle is taken while results drain freely. A tick
// that fires a heartbeat yields two results and holds the output for two
// transfers. The input side stalls while a waiting result sees m_tready low,
// and while the second result of a heartbeat tick is still waiting.
// Reset clears all counters and restores the register defaults; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module can_command_check_and_heartbeat (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame_id[10:0], rx_payload[74:11], tlm_accepted[75], hb_accepted[76],
	// latitude[100:77], longitude[124:101], satellites[132:125],
	// fix_kind[140:133], zero[143:141]
	input  logic [143:0] s_tdata,
	// req_type[0]
	input  logic         s_tuser,
	// Output stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_frame_id[10:0], out_payload[74:11], rx_status[76:75],
	// error_total[108:77], zero[111:109]
	output logic [111:0] m_tdata,
	// out_kind[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	cchb_pkg::cfg_t    cfg_q;
	cchb_pkg::item_t   item_s1;
	cchb_pkg::result_t res0;
	cchb_pkg::result_t res1;
	cchb_pkg::result_t out_res;
	logic              valid_s1;
	logic              out_free;
	logic              two;
	logic              adv;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id      <= cchb_pkg::RST_NODE_ID;
			cfg_q.node_status  <= cchb_pkg::RST_NODE_STATUS;
			cfg_q.command_id   <= cchb_pkg::RST_COMMAND_ID;
			cfg_q.telemetry_id <= cchb_pkg::RST_TELEMETRY_ID;
			cfg_q.hb_base_id   <= cchb_pkg::RST_HB_BASE_ID;
			cfg_q.hb_period    <= cchb_pkg::RST_HB_PERIOD;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				cchb_pkg::REG_NODE_ID:      cfg_q.node_id      <= pwdata[7:0];
				cchb_pkg::REG_NODE_STATUS:  cfg_q.node_status  <= pwdata[1:0];
				cchb_pkg::REG_COMMAND_ID:   cfg_q.command_id   <= pwdata[10:0];
				cchb_pkg::REG_TELEMETRY_ID: cfg_q.telemetry_id <= pwdata[10:0];
				cchb_pkg::REG_HB_BASE_ID:   cfg_q.hb_base_id   <= pwdata[10:0];
				cchb_pkg::REG_HB_PERIOD:    cfg_q.hb_period    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			cchb_pkg::REG_NODE_ID:      prdata = {24'd0, cfg_q.node_id};
			cchb_pkg::REG_NODE_STATUS:  prdata = {30'd0, cfg_q.node_status};
			cchb_pkg::REG_COMMAND_ID:   prdata = {21'd0, cfg_q.command_id};
			cchb_pkg::REG_TELEMETRY_ID: prdata = {21'd0, cfg_q.telemetry_id};
			cchb_pkg::REG_HB_BASE_ID:   prdata = {21'd0, cfg_q.hb_base_id};
			cchb_pkg::REG_HB_PERIOD:    prdata = {24'd0, cfg_q.hb_period};
			default:                    prdata = 32'd0;
		endcase
	end

	cchb_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.req_type     (s_tuser),
		.frame_id     (s_tdata[10:0]),
		.rx_payload   (s_tdata[74:11]),
		.tlm_accepted (s_tdata[75]),
		.hb_accepted  (s_tdata[76]),
		.latitude     (s_tdata[100:77]),
		.longitude    (s_tdata[124:101]),
		.satellites   (s_tdata[132:125]),
		.fix_kind     (s_tdata[140:133]),
		.command_id   (cfg_q.command_id),
		.take         (out_free),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	assign adv = valid_s1 && out_free;

	cchb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.adv     (adv),
		.item_s1 (item_s1),
		.res0    (res0),
		.res1    (res1),
		.two     (two)
	);

	cchb_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res0      (res0),
		.res1      (res1),
		.two       (two),
		.free      (out_free),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res)
	);

	// Output packing.
	assign m_tdata = {3'd0, out_res.error_total, out_res.rx_status, out_res.payload,
		out_res.frame_id};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

// File: tb/cchb_checker.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: result checker
// Watches the register port and both streams. It keeps its own copy of the
// node's registers and counters, works out the results of every input
// transfer and compares each output transfer, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
module cchb_checker
	import cchb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	output int           fails,
	output int           pending
);

	// Register copy.
	logic [7:0]  node_id;
	logic [1:0]  node_status;
	logic [10:0] command_id;
	logic [10:0] telemetry_id;
	logic [10:0] hb_base_id;
	logic [7:0]  hb_period;

	// Node counters.
	logic [7:0]  tick_phase;
	logic [15:0] uptime;
	logic [31:0] sent_count;
	logic [31:0] rcvd_count;
	logic [31:0] error_count;

	// Frames the node still owes, oldest first.
	result_t expected_frames[$];
	result_t oldest;

	// CRC-8 over bytes 0 to 5, shifted in one bit at a time, MSB first.
	function automatic logic [7:0] crc8_of(input logic [47:0] bytes);
		logic [7:0] crc;
		logic       feedback;
		crc = 8'h00;
		for (int k = 47; k >= 0; k--) begin
			feedback = crc[7] ^ bytes[k];
			crc = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// Work out the frames caused by one input transfer and update the counters.
	task automatic predict_frames(input logic req, input logic [143:0] d);
		logic [63:0] pl;
		logic [1:0]  status;
		logic        fire;
		result_t     r;
		pl = d[74:11];
		if (req == REQ_RX_FRAME) begin
			status = RXST_NOT_CMD;
			rcvd_count = rcvd_count + 1;
			if (d[10:0] == command_id) begin
				if (crc8_of(pl[63:16]) == pl[15:8]) begin
					status = RXST_CMD_OK;
					if (pl[63:56] == CMD_RESET_COUNTS) begin
						sent_count = '0;
						rcvd_count = '0;
						error_count = '0;
					end
				end else begin
					status = RXST_CRC_ERR;
					error_count = error_count + 1;
				end
			end
			r = '{KIND_STATUS, 11'd0, 64'd0, status, error_count, 1'b1};
			expected_frames.push_back(r);
		end else begin
			// Telemetry first; a rejected one counts as an error.
			if (d[75]) begin
				sent_count = sent_count + 1;
			end else begin
				error_count = error_count + 1;
			end
			tick_phase = tick_phase + 8'd1;
			fire = (tick_phase >= hb_period);
			if (fire) begin
				tick_phase = '0;
			end
			r = '{KIND_TELEMETRY, telemetry_id,
				{d[100:77], d[124:101], d[132:125], d[140:133]},
				RXST_NONE, error_count, !fire};
			expected_frames.push_back(r);
			// Heartbeat carries the counts before its own transfer is counted.
			if (fire) begin
				r = '{KIND_HEARTBEAT, hb_base_id + {3'b000, node_id},
					{node_id, 6'b000000, node_status, uptime,
					 sent_count[15:0], rcvd_count[15:0]},
					RXST_NONE, error_count, 1'b1};
				if (d[76]) begin
					sent_count = sent_count + 1;
				end
				uptime = uptime + 16'd1;
				expected_frames.push_back(r);
			end
		end
	endtask

	// Compare one field and report a mismatch.
	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name,
				want, got);
			fails = fails + 1;
		end
	endtask

	// Everything is sampled at the rising edge, before the edge's updates land.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id      = RST_NODE_ID;
			node_status  = RST_NODE_STATUS;
			command_id   = RST_COMMAND_ID;
			telemetry_id = RST_TELEMETRY_ID;
			hb_base_id   = RST_HB_BASE_ID;
			hb_period    = RST_HB_PERIOD;
			tick_phase   = '0;
			uptime       = '0;
			sent_count   = '0;
			rcvd_count   = '0;
			error_count  = '0;
			expected_frames.delete();
			pending <= 0;
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_NODE_ID:      node_id = pwdata[7:0];
					REG_NODE_STATUS:  node_status = pwdata[1:0];
					REG_COMMAND_ID:   command_id = pwdata[10:0];
					REG_TELEMETRY_ID: telemetry_id = pwdata[10:0];
					REG_HB_BASE_ID:   hb_base_id = pwdata[10:0];
					REG_HB_PERIOD:    hb_period = pwdata[7:0];
					default: ;
				endcase
			end

			// Input transfer.
			if (s_tvalid && s_tready) begin
				predict_frames(s_tuser, s_tdata);
			end

			// Output transfer.
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: unexpected frame: expected none, actual kind %h id %h data %h",
						$time, m_tuser, m_tdata[10:0], m_tdata[74:11]);
					fails = fails + 1;
				end else begin
					oldest = expected_frames.pop_front();
					check_field("kind", 64'(oldest.kind), 64'(m_tuser));
					check_field("frame_id", 64'(oldest.frame_id), 64'(m_tdata[10:0]));
					check_field("payload", oldest.payload, m_tdata[74:11]);
					check_field("rx_status", 64'(oldest.rx_status), 64'(m_tdata[76:75]));
					check_field("error_total", 64'(oldest.error_total),
						64'(m_tdata[108:77]));
					check_field("last", 64'(oldest.last), 64'(m_tlast));
				end
			end

			pending <= expected_frames.size();
		end
	end

endmodule

// File: tb/can_command_check_and_heartbeat_test.sv
// ----------------------------------------------------------------------------
// CAN command check and heartbeat: testbench top
// Drives received frames and ticks into the node with random gaps, stalls the
// output at random, and rewrites the registers between phases while the node
// is idle. Checking is done by the checker instance beside the node.
// ----------------------------------------------------------------------------
module can_command_check_and_heartbeat_test;
	import cchb_pkg::*;

	localparam int TIMEOUT = 5_000_000;
	localparam int SETTLE  = 12;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	int fails;
	int pending;

	// Current command id, used to build command frames.
	logic [10:0] cmd_id;
	// Set for phases that run without any gaps.
	bit steady;

	can_command_check_and_heartbeat dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	cchb_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fails(fails), .pending(pending)
	);

	always #5 clk = ~clk;

	// Hard stop in case the node hangs.
	initial begin
		#(TIMEOUT);
		$display("== FAIL ==");
		$finish;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Command payload with byte 6 set to the CRC of bytes 0 to 5.
	function automatic logic [63:0] good_cmd(input logic [63:0] pl);
		logic [63:0] f;
		f = pl;
		f[15:8] = crc8_six(f);
		return f;
	endfunction

	// One input transfer, after a random gap.
	task automatic send_item(input logic req, input logic [143:0] data);
		int n;
		n = pick_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Received frame; the tick fields carry random noise.
	task automatic send_rx(input logic [10:0] fid, input logic [63:0] pl);
		logic [143:0] d;
		d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		d[143:141] = 3'b000;
		d[74:0] = {pl, fid};
		send_item(REQ_RX_FRAME, d);
	endtask

	// Tick; frame id and payload carry random noise.
	task automatic send_tick(input logic tlm, input logic hb, input logic [23:0] lat,
		input logic [23:0] lon, input logic [7:0] sats, input logic [7:0] fix);
		logic [143:0] d;
		d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		d[143:75] = {3'b000, fix, sats, lon, lat, hb, tlm};
		send_item(REQ_TICK, d);
	endtask

	// Drop valid, wait until every expected frame has come, then let it settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all six registers, each with a setup and an access phase.
	task automatic write_cfg(input logic [7:0] node, input logic [1:0] status,
		input logic [10:0] cmd, input logic [10:0] tlm, input logic [10:0] base,
		input logic [7:0] period);
		logic [31:0] vals[6];
		vals[REG_NODE_ID]      = {24'd0, node};
		vals[REG_NODE_STATUS]  = {30'd0, status};
		vals[REG_COMMAND_ID]   = {21'd0, cmd};
		vals[REG_TELEMETRY_ID] = {21'd0, tlm};
		vals[REG_HB_BASE_ID]   = {21'd0, base};
		vals[REG_HB_PERIOD]    = {24'd0, period};
		for (int i = 0; i < 6; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {i[2:0], 2'b00};
			pwdata  <= vals[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cmd_id = cmd;
	endtask

	// Output side: ready drops for random stretches.
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [63:0] pl;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_RX_FRAME;
		cmd_id   = RST_COMMAND_ID;
		steady   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: id extremes, good and bad commands, a command with another
		// byte 0, field extremes on ticks, rejected telemetry frames, a
		// rejected heartbeat, then the counter-clearing command.
		send_rx(11'h000, 64'h0);
		send_rx(11'h7FF, '1);
		send_rx(cmd_id, good_cmd(64'h55AA_0102_0304_0000));
		send_rx(cmd_id, good_cmd(64'h0));
		pl = good_cmd('1);
		pl[15:8] = ~pl[15:8];
		send_rx(cmd_id, pl);
		for (int k = 0; k < 10; k++) begin
			send_tick(k % 4 != 3, k != 9,
				k[0] ? 24'h7FFFFF : 24'h800000, k[0] ? 24'h800000 : 24'h7FFFFF,
				k[0] ? 8'hFF : 8'h00, k[0] ? 8'h00 : 8'hFF);
		end
		send_rx(cmd_id, good_cmd({CMD_RESET_COUNTS, 48'h1234_5678_9ABC, 8'h00}));
		send_tick(1'b1, 1'b1, 24'h000001, 24'hFFFFFF, 8'd12, 8'd1);

		// Random phases, each under its own register setting.
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: write_cfg(8'hFF, 2'd3, 11'h7FF, 11'h7FF, 11'h7FF, 8'd255);
				// Period drops below the phase left by the slow phase before.
				1: write_cfg(8'h00, 2'd0, 11'h000, 11'h000, 11'h000, 8'd1);
				2: write_cfg(8'($urandom), 2'd2, 11'($urandom), 11'($urandom),
					11'($urandom), 8'd0);
				default: write_cfg(8'($urandom), 2'($urandom_range(0, 3)),
					11'($urandom), 11'($urandom), 11'($urandom),
					8'($urandom_range(1, 12)));
			endcase
			steady = ($urandom_range(0, 3) == 0);
			repeat (100) begin
				int r;
				logic [63:0] rp;
				r = $urandom_range(0, 99);
				rp = {$urandom, $urandom};
				if (r < 50) begin
					send_tick($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
						24'($urandom), 24'($urandom), 8'($urandom), 8'($urandom));
				end else if (r < 70) begin
					if ($urandom_range(0, 5) == 0) begin
						rp[63:56] = CMD_RESET_COUNTS;
					end
					send_rx(cmd_id, good_cmd(rp));
				end else if (r < 80) begin
					rp = good_cmd(rp);
					rp[15:8] ^= 8'($urandom_range(1, 255));
					send_rx(cmd_id, rp);
				end else if (r < 85) begin
					// Id one bit away from the command id.
					send_rx(cmd_id ^ (11'd1 << $urandom_range(0, 10)), rp);
				end else begin
					send_rx(11'($urandom), rp);
				end
			end
		end

		wait_idle();
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
